// File: hw/rtl/prq_pkg.sv
package prq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;

    localparam int ID_W   = 32;
    localparam int PRIO_W = 8;
    localparam int TIME_W = 64;

    typedef enum logic [0:0] {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_ARG = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [ID_W-1:0]     new_thread_id;
        logic [PRIO_W-1:0]   new_priority;
        logic [TIME_W-1:0]   new_enqueue_time;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [ID_W-1:0]     popped_thread_id;
        logic [PRIO_W-1:0]   popped_priority;
        logic [TIME_W-1:0]   popped_enqueue_time;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PRIO_W-1:0]   prio;
        logic [TIME_W-1:0]   stamp;
    } t_entry;

endpackage

// File: hw/rtl/prq_stream_if.sv
interface prq_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/priority_run_queue.sv
// priority run queue: holds up to QUEUE_DEPTH thread entries (id, priority,
// enqueue timestamp) in a single-port-write, registered-read memory. a push
// (kind 0) is answered in the cycle after it is taken: status ok, bad argument
// for id zero (checked first) or full. a pop (kind 1) scans the stored
// entries one per cycle through a single priority/timestamp comparator,
// picks the highest priority (smaller timestamp, then lower slot wins ties),
// then moves every later entry down one slot, one slot per cycle, through
// the same memory port, and then hands out the winner. a pop of an empty
// queue answers "empty" like a push. the next request is taken only once
// the sequencer is idle and the result register is free or being emptied
// in the same cycle. no clearing pass is needed after reset: only slots
// below the count are ever used, and those were always written.
module priority_run_queue #(
    parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prq_stream_if.sink   i_req,
    prq_stream_if.source o_rsp
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // entry store, read data registered
    prq_pkg::t_entry r_mem [QUEUE_DEPTH];
    prq_pkg::t_entry r_rd_data;

    // sequencer and bookkeeping
    prq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_ptr,   n_ptr;     // scan position, then shift target
    logic [IDX_W-1:0] r_sel,   n_sel;     // best slot found so far
    prq_pkg::t_entry  r_best,  n_best;

    // result register
    logic          r_out_valid, n_out_valid;
    prq_pkg::t_rsp r_out,       n_out;

    // memory port controls
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    prq_pkg::t_entry  wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    logic             in_ready;
    logic             take;
    logic [CNT_W-1:0] ptr_inc;
    logic             is_better;
    logic [IDX_W-1:0] cand_sel;
    prq_pkg::t_entry  cand_best;
    prq_pkg::t_entry  new_entry;

    assign in_ready = (r_state == prq_pkg::S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign take     = i_req.valid && in_ready;
    assign ptr_inc  = CNT_W'(r_ptr) + CNT_W'(1);

    assign new_entry.id    = i_req.payload.new_thread_id;
    assign new_entry.prio  = i_req.payload.new_priority;
    assign new_entry.stamp = i_req.payload.new_enqueue_time;

    // the shared comparator: the first slot always wins, later ones only if
    // strictly better so the lower slot keeps a full tie
    assign is_better = (r_ptr == '0)
                    || (r_rd_data.prio > r_best.prio)
                    || ((r_rd_data.prio == r_best.prio) && (r_rd_data.stamp < r_best.stamp));
    assign cand_sel  = is_better ? r_ptr : r_sel;
    assign cand_best = is_better ? r_rd_data : r_best;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_sel       = r_sel;
        n_best      = r_best;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_ptr;
        wr_data     = r_rd_data;
        rd_en       = 1'b0;
        rd_addr     = IDX_W'(ptr_inc);

        unique case (r_state)
            prq_pkg::S_IDLE: begin
                if (take) begin
                    n_out.popped_thread_id    = '0;
                    n_out.popped_priority     = '0;
                    n_out.popped_enqueue_time = '0;
                    if (i_req.payload.kind == prq_pkg::KIND_PUSH) begin
                        n_out_valid = 1'b1;
                        priority if (i_req.payload.new_thread_id == '0) begin
                            n_out.status = prq_pkg::STATUS_BAD_ARG;
                        end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_out.status = prq_pkg::STATUS_FULL;
                        end else begin
                            n_out.status = prq_pkg::STATUS_OK;
                            wr_en        = 1'b1;
                            wr_addr      = IDX_W'(r_count);
                            wr_data      = new_entry;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out.status = prq_pkg::STATUS_EMPTY;
                    end else begin
                        // fetch slot zero, scan starts next cycle
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_ptr   = '0;
                        n_state = prq_pkg::S_SCAN;
                    end
                end
            end

            prq_pkg::S_SCAN: begin
                n_best = cand_best;
                n_sel  = cand_sel;
                rd_en  = 1'b1;
                if (ptr_inc == r_count) begin
                    // last entry compared: fetch the slot above the winner
                    n_ptr   = cand_sel;
                    rd_addr = IDX_W'(CNT_W'(cand_sel) + CNT_W'(1));
                    n_state = prq_pkg::S_SHIFT;
                end else begin
                    n_ptr   = IDX_W'(ptr_inc);
                    rd_addr = IDX_W'(ptr_inc);
                end
            end

            prq_pkg::S_SHIFT: begin
                if (ptr_inc < r_count) begin
                    // r_rd_data holds slot ptr+1, move it down
                    wr_en   = 1'b1;
                    wr_addr = r_ptr;
                    wr_data = r_rd_data;
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(ptr_inc + CNT_W'(1));
                    n_ptr   = IDX_W'(ptr_inc);
                end else begin
                    // gap closed, hand out the winner
                    n_count                   = r_count - CNT_W'(1);
                    n_out_valid               = 1'b1;
                    n_out.status              = prq_pkg::STATUS_OK;
                    n_out.popped_thread_id    = r_best.id;
                    n_out.popped_priority     = r_best.prio;
                    n_out.popped_enqueue_time = r_best.stamp;
                    n_state                   = prq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = prq_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_sel  <= n_sel;
        r_best <= n_best;
        r_out  <= n_out;
    end

    // entry memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign i_req.ready   = in_ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

// File: hw/rtl/prq_checker.sv
module prq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input prq_pkg::t_req i_req_payload,
    input logic          o_rsp_valid,
    input logic          o_rsp_ready,
    input prq_pkg::t_rsp o_rsp_payload
);

    // a pending response holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid)
        else $error("response dropped before transaction");

    // new requests only when the result register is free on this edge
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_ready |-> (!o_rsp_valid || o_rsp_ready))
        else $error("request taken while response stalled");

    // a push is answered in the next cycle
    a_push_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_payload.kind == prq_pkg::KIND_PUSH)
        |=> o_rsp_valid)
        else $error("push not answered in one cycle");

    // push of id zero is refused as bad argument
    a_bad_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_payload.kind == prq_pkg::KIND_PUSH)
        && (i_req_payload.new_thread_id == '0)
        |=> o_rsp_payload.status == prq_pkg::STATUS_BAD_ARG)
        else $error("id zero push not refused");

    // refused or empty answers carry no entry
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp_payload.status != prq_pkg::STATUS_OK)
        |-> (o_rsp_payload.popped_thread_id == '0)
            && (o_rsp_payload.popped_priority == '0)
            && (o_rsp_payload.popped_enqueue_time == '0))
        else $error("non-ok response carries entry data");

endmodule

bind priority_run_queue prq_checker u_prq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_payload (i_req.payload),
    .o_rsp_valid   (o_rsp.valid),
    .o_rsp_ready   (o_rsp.ready),
    .o_rsp_payload (o_rsp.payload)
);
